/* src/integer_calculator_alu_macros.svh */
// Assertion macros for the integer calculator ALU.
// No dependencies; included by files that carry concurrent checks.
`ifndef INTEGER_CALCULATOR_ALU_MACROS_SVH
`define INTEGER_CALCULATOR_ALU_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define ICALC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icalc check failed");
// antecedent holds -> consequent holds in the next cycle
`define ICALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icalc check failed");
`else
`define ICALC_ASSERT_SAME(label, clk, rst, ante, cons)
`define ICALC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/icalc_pkg.sv */
// Shared types and constants for the integer calculator ALU.
// No dependencies; imported by the multiplier, divider and top level.
package icalc_pkg;

   localparam int FIELD_W = 32;
   localparam int MODE_W  = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_DIV  = 3'd3,
      MODE_POW  = 3'd4,
      MODE_FACT = 3'd5
   } mode_type;

   // handshake status of an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

/* src/icalc_mul.sv */
// Iterative multiplier: low DATA_WIDTH bits of x*y, one digit of y (16 bits, or DATA_WIDTH if narrower) per cycle.
// Depends on icalc_pkg (unit_status_type).
module icalc_mul
   import icalc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] mul_x,
   input  logic [DATA_WIDTH-1:0] mul_y,
   output unit_status_type       status,
   output logic [DATA_WIDTH-1:0] product
);

   localparam int DIG_W  = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
   localparam int NDIG   = (DATA_WIDTH + DIG_W - 1) / DIG_W;
   localparam int CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PP_W   = DATA_WIDTH + DIG_W;

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] x_ff, y_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;
   logic [PP_W-1:0]       pp;

   always_comb begin
      pp     = PP_W'(x_ff) * PP_W'(y_ff[DIG_W-1:0]);
      acc_in = acc_ff + pp[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(NDIG - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            acc_ff  <= '0;
            x_ff    <= mul_x;
            y_ff    <= mul_y;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            // advance to the next digit of y
            x_ff   <= x_ff << DIG_W;
            y_ff   <= y_ff >> DIG_W;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NDIG - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

/* src/icalc_div.sv */
// Restoring radix-2 divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on icalc_pkg (unit_status_type).
module icalc_div
   import icalc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output unit_status_type       status,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;
   logic [DATA_WIDTH:0]   shifted, diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = shifted >= {1'b0, div_ff};
      rem_in  = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_in  = {quo_ff[DATA_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(DATA_WIDTH - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

/* src/integer_calculator_alu.sv */
// Signed integer calculator: add, subtract, multiply, divide, power and factorial at
// DATA_WIDTH bits, wrapping two's complement, one result beat per request beat. The block
// takes one request at a time and holds req_stall high until the result is in the output
// register. Add, subtract and unused modes compute the result when the request is taken
// and go straight to the finish state. Products run on one shared multiplier that consumes
// 16 bits of the second factor per cycle; divide runs a restoring divider on the operand
// magnitudes. Power uses square-and-multiply: up to 2*bits(exponent)-1 multiplications.
// Factorial needs one multiplication per factor and stops once the product wraps to zero
// (argument 34 at 32 bits).
// Depends on icalc_pkg, icalc_mul, icalc_div and integer_calculator_alu_macros.svh.
`include "integer_calculator_alu_macros.svh"
module integer_calculator_alu
   import icalc_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic signed [FIELD_W-1:0] req_operand_a,
   input  logic signed [FIELD_W-1:0] req_operand_b,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [FIELD_W-1:0] rsp_result,
   output logic signed [FIELD_W-1:0] rsp_remainder_out,
   output logic                      rsp_divide_by_zero
);

   localparam int EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_POW_CHK,
      ST_POW_ACC,
      ST_POW_SQ,
      ST_FACT_MUL,
      ST_FACT_WAIT,
      ST_FINISH
   } state_type;

   state_type             state_ff;
   logic                  rsp_valid_ff;
   logic [FIELD_W-1:0]    rsp_result_ff, rsp_rem_ff;
   logic                  rsp_dz_ff;

   logic [DATA_WIDTH-1:0] res_ff, rem_ff;
   logic                  dz_ff;
   logic [DATA_WIDTH-1:0] acc_ff, base_ff, expo_ff, idx_ff;
   logic                  neg_q_ff, neg_r_ff;

   logic                  mul_start_ff, div_start_ff;
   logic                  mul_start_in, div_start_in;
   logic [DATA_WIDTH-1:0] mul_x_ff, mul_y_ff, div_x_ff, div_y_ff;
   unit_status_type       mul_status, div_status;
   logic [DATA_WIDTH-1:0] mul_product, div_quo, div_rem;

   logic [EXT_W-1:0]      a_ext, b_ext, res_ext, rem_ext;
   logic [DATA_WIDTH-1:0] a_w, b_w, a_mag, b_mag;
   logic                  a_neg, b_neg;

   // sign-extend the operands, then take them at the working width
   always_comb begin
      a_ext   = EXT_W'(req_operand_a);
      b_ext   = EXT_W'(req_operand_b);
      a_w     = a_ext[DATA_WIDTH-1:0];
      b_w     = b_ext[DATA_WIDTH-1:0];
      a_neg   = a_w[DATA_WIDTH-1];
      b_neg   = b_w[DATA_WIDTH-1];
      a_mag   = a_neg ? (DATA_WIDTH'(0) - a_w) : a_w;
      b_mag   = b_neg ? (DATA_WIDTH'(0) - b_w) : b_w;
      res_ext = EXT_W'(res_ff);
      rem_ext = EXT_W'(rem_ff);
   end

   // launch pulses for the multiplier and divider
   always_comb begin
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            mul_start_in = req_valid && (req_mode == MODE_MUL);
            div_start_in = req_valid && (req_mode == MODE_DIV) && (b_w != '0);
         end
         ST_POW_CHK:  mul_start_in = (expo_ff != '0);
         ST_POW_ACC:  mul_start_in = mul_status.done && (expo_ff != DATA_WIDTH'(1));
         ST_FACT_MUL: mul_start_in = 1'b1;
         default: ;
      endcase
   end

   icalc_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mul_x   (mul_x_ff),
      .mul_y   (mul_y_ff),
      .status  (mul_status),
      .product (mul_product)
   );

   icalc_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_x_ff),
      .divisor   (div_y_ff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         // drop a taken beat unless the next one loads now
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  rem_ff <= '0;
                  dz_ff  <= (req_mode == MODE_DIV) && (b_w == '0);
                  case (mode_type'(req_mode))
                     MODE_ADD: begin
                        res_ff   <= a_w + b_w;
                        state_ff <= ST_FINISH;
                     end
                     MODE_SUB: begin
                        res_ff   <= a_w - b_w;
                        state_ff <= ST_FINISH;
                     end
                     MODE_MUL: begin
                        mul_x_ff <= a_w;
                        mul_y_ff <= b_w;
                        state_ff <= ST_MUL;
                     end
                     MODE_DIV: begin
                        if (b_w == '0) begin
                           res_ff   <= '0;
                           state_ff <= ST_FINISH;
                        end else begin
                           div_x_ff <= a_mag;
                           div_y_ff <= b_mag;
                           neg_q_ff <= a_neg ^ b_neg;
                           neg_r_ff <= a_neg;
                           state_ff <= ST_DIV;
                        end
                     end
                     MODE_POW: begin
                        if (b_neg || b_w == '0) begin
                           res_ff   <= DATA_WIDTH'(1);
                           state_ff <= ST_FINISH;
                        end else begin
                           acc_ff   <= DATA_WIDTH'(1);
                           base_ff  <= a_w;
                           expo_ff  <= b_w;
                           state_ff <= ST_POW_CHK;
                        end
                     end
                     MODE_FACT: begin
                        if (a_neg || a_w <= DATA_WIDTH'(1)) begin
                           res_ff   <= DATA_WIDTH'(1);
                           state_ff <= ST_FINISH;
                        end else begin
                           acc_ff   <= DATA_WIDTH'(1);
                           base_ff  <= a_w;
                           idx_ff   <= DATA_WIDTH'(2);
                           state_ff <= ST_FACT_MUL;
                        end
                     end
                     default: begin
                        res_ff   <= '0;
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_MUL: begin
               if (mul_status.done) begin
                  res_ff   <= mul_product;
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIV: begin
               if (div_status.done) begin
                  res_ff   <= neg_q_ff ? (DATA_WIDTH'(0) - div_quo) : div_quo;
                  rem_ff   <= neg_r_ff ? (DATA_WIDTH'(0) - div_rem) : div_rem;
                  state_ff <= ST_FINISH;
               end
            end
            ST_POW_CHK: begin
               if (expo_ff == '0) begin
                  res_ff   <= acc_ff;
                  state_ff <= ST_FINISH;
               end else if (expo_ff[0]) begin
                  mul_x_ff <= acc_ff;
                  mul_y_ff <= base_ff;
                  state_ff <= ST_POW_ACC;
               end else begin
                  mul_x_ff <= base_ff;
                  mul_y_ff <= base_ff;
                  state_ff <= ST_POW_SQ;
               end
            end
            ST_POW_ACC: begin
               if (mul_status.done) begin
                  acc_ff <= mul_product;
                  // last exponent bit: skip the final squaring
                  if (expo_ff == DATA_WIDTH'(1)) begin
                     res_ff   <= mul_product;
                     state_ff <= ST_FINISH;
                  end else begin
                     mul_x_ff <= base_ff;
                     mul_y_ff <= base_ff;
                     state_ff <= ST_POW_SQ;
                  end
               end
            end
            ST_POW_SQ: begin
               if (mul_status.done) begin
                  base_ff  <= mul_product;
                  expo_ff  <= expo_ff >> 1;
                  state_ff <= ST_POW_CHK;
               end
            end
            ST_FACT_MUL: begin
               mul_x_ff <= acc_ff;
               mul_y_ff <= idx_ff;
               state_ff <= ST_FACT_WAIT;
            end
            ST_FACT_WAIT: begin
               if (mul_status.done) begin
                  acc_ff <= mul_product;
                  // a product that wrapped to zero stays zero
                  if (mul_product == '0 || idx_ff == base_ff) begin
                     res_ff   <= mul_product;
                     state_ff <= ST_FINISH;
                  end else begin
                     idx_ff   <= idx_ff + DATA_WIDTH'(1);
                     state_ff <= ST_FACT_MUL;
                  end
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_result_ff <= res_ext[FIELD_W-1:0];
                  rsp_rem_ff    <= rem_ext[FIELD_W-1:0];
                  rsp_dz_ff     <= dz_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_remainder_out  = rsp_rem_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   `ICALC_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall)
   `ICALC_ASSERT_SAME(a_dz_zeros, clock, reset, rsp_valid && rsp_divide_by_zero,
                      rsp_result == '0 && rsp_remainder_out == '0)
   `ICALC_ASSERT_SAME(a_one_unit, clock, reset, mul_status.busy, !div_status.busy)
   `ICALC_ASSERT_SAME(a_mul_done_state, clock, reset, mul_status.done,
                      state_ff == ST_MUL || state_ff == ST_POW_ACC ||
                      state_ff == ST_POW_SQ || state_ff == ST_FACT_WAIT)

endmodule
